### rtl/tilt_fusion_balance_pd_top_defines.svh
// Assertion macros shared by the tilt fusion and PD balance modules
`ifndef TILT_FUSION_BALANCE_PD_TOP_DEFINES_SVH
`define TILT_FUSION_BALANCE_PD_TOP_DEFINES_SVH

// check a property at every clk edge outside reset
`define TFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// check that a cause is followed by an effect in the next clk cycle, outside reset
`define TFB_ASSERT_NEXT(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error(msg);

`endif

### rtl/tfb_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the tilt fusion and PD balance block
package tfb_pkg;

  localparam int W_TILT     = 16;
  localparam int W_GYRO     = 16;
  localparam int W_SETPT    = 26;
  localparam int W_GAIN     = 16;
  localparam int W_GOFF     = 24;
  localparam int W_TOFF     = 16;
  localparam int W_CFG_DATA = 26;
  localparam int W_CFG_IDX  = 3;

  localparam int W_DRIVE = 17;
  localparam int W_ANGLE = 26;
  localparam int W_RATE  = 29;

  localparam int W_PDEV  = 25;
  localparam int W_YMAG  = 17;
  localparam int W_TDEV  = 17;
  localparam int W_ERR   = 28;
  localparam int W_RA    = 38;
  localparam int W_R24   = 39;
  localparam int W_RFLR  = 31;
  localparam int W_FI    = 32;
  localparam int W_FSUM  = 33;
  localparam int W_X     = 34;
  localparam int W_ASUM  = 27;
  localparam int W_PDERR = 27;
  localparam int W_SUM   = 46;

  localparam int W_MC   = 34;
  localparam int W_MP   = 32;
  localparam int W_PROD = W_MC + W_MP;
  localparam int W_DIG  = 4;
  localparam int W_NDIG = 4;

  localparam logic [W_CFG_IDX-1:0] REG_ANGLE_SETPOINT    = 3'd0;
  localparam logic [W_CFG_IDX-1:0] REG_ANGLE_GAIN_P      = 3'd1;
  localparam logic [W_CFG_IDX-1:0] REG_ANGLE_GAIN_D      = 3'd2;
  localparam logic [W_CFG_IDX-1:0] REG_GYRO_PITCH_OFFSET = 3'd3;
  localparam logic [W_CFG_IDX-1:0] REG_TILT_OFFSET       = 3'd4;

  localparam logic signed [W_GOFF-1:0] GOFF_RESET = 24'sd1485;
  localparam logic signed [W_TOFF-1:0] TOFF_RESET = -16'sd2560;

  // multiplier constants, left-justified so the top digit leads
  localparam logic [W_MP-1:0] MPL_RATE     = 32'd7471 << 16;
  localparam logic [W_MP-1:0] MPL_YAW_NEG  = 32'd19126 << 16;
  localparam logic [W_MP-1:0] MPL_YAW_POS  = 32'd9563 << 16;
  localparam logic [W_MP-1:0] MPL_INT      = 32'd309238 << 12;
  localparam logic [W_MP-1:0] MPL_PROP     = 32'd4123168604;
  localparam logic [W_MP-1:0] MPL_DT       = 32'd1342177 << 8;
  localparam logic [W_NDIG-1:0] NDIG_RATE  = 4'd4;
  localparam logic [W_NDIG-1:0] NDIG_YAW   = 4'd4;
  localparam logic [W_NDIG-1:0] NDIG_INT   = 4'd5;
  localparam logic [W_NDIG-1:0] NDIG_PROP  = 4'd8;
  localparam logic [W_NDIG-1:0] NDIG_DT    = 4'd6;
  localparam logic [W_NDIG-1:0] NDIG_GAIN  = 4'd4;

  localparam logic signed [W_RATE-1:0]  RATE_MAX  = 29'sd268435455;
  localparam logic signed [W_RATE-1:0]  RATE_MIN  = -29'sd268435455;
  localparam logic signed [W_ANGLE-1:0] ANGLE_MAX = 26'sd26214400;
  localparam logic signed [W_ANGLE-1:0] ANGLE_MIN = -26'sd26214400;
  localparam logic signed [W_FI-1:0]    FI_MAX    = 32'sh7FFFFFFF;
  localparam logic signed [W_FI-1:0]    FI_MIN    = 32'sh80000000;
  localparam logic signed [W_DRIVE-1:0] DRIVE_MAX = 17'sd50000;
  localparam logic signed [W_DRIVE-1:0] DRIVE_MIN = -17'sd50000;
  localparam logic signed [W_SUM-1:0]   DRIVE_LIM = 46'sd838860800000;
  localparam logic signed [W_SUM-1:0]   DRIVE_LIM_N = -46'sd838860800000;
  localparam logic signed [W_SUM-1:0]   DRIVE_ROUND = 46'sd16777215;

  typedef struct packed {
    logic signed [W_SETPT-1:0] angle_setpoint;
    logic [W_GAIN-1:0]         angle_gain_p;
    logic [W_GAIN-1:0]         angle_gain_d;
    logic signed [W_GOFF-1:0]  gyro_pitch_offset;
    logic signed [W_TOFF-1:0]  tilt_offset;
  } cfg_t;

  typedef struct packed {
    logic                    start;
    logic signed [W_MC-1:0]  mcand;
    logic [W_MP-1:0]         mplier;
    logic [W_NDIG-1:0]       ndig;
  } mul_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [W_PROD-1:0] product;
  } mul_rsp_t;

endpackage

### rtl/tfb_cfg.sv
`timescale 1ns / 1ps
// Configuration register file of the tilt fusion and PD balance block
module tfb_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tfb_pkg::W_CFG_IDX-1:0]    cfg_index,
  input  logic [tfb_pkg::W_CFG_DATA-1:0]   cfg_data,
  output tfb_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_setpoint    <= '0;
      cfg.angle_gain_p      <= '0;
      cfg.angle_gain_d      <= '0;
      cfg.gyro_pitch_offset <= tfb_pkg::GOFF_RESET;
      cfg.tilt_offset       <= tfb_pkg::TOFF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tfb_pkg::REG_ANGLE_SETPOINT: begin
          cfg.angle_setpoint <= $signed(cfg_data[tfb_pkg::W_SETPT-1:0]);
        end
        tfb_pkg::REG_ANGLE_GAIN_P: begin
          cfg.angle_gain_p <= cfg_data[tfb_pkg::W_GAIN-1:0];
        end
        tfb_pkg::REG_ANGLE_GAIN_D: begin
          cfg.angle_gain_d <= cfg_data[tfb_pkg::W_GAIN-1:0];
        end
        tfb_pkg::REG_GYRO_PITCH_OFFSET: begin
          cfg.gyro_pitch_offset <= $signed(cfg_data[tfb_pkg::W_GOFF-1:0]);
        end
        tfb_pkg::REG_TILT_OFFSET: begin
          cfg.tilt_offset <= $signed(cfg_data[tfb_pkg::W_TOFF-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/tfb_smul.sv
`timescale 1ns / 1ps
// Digit-serial signed by unsigned multiplier, one 4-bit digit per cycle, MSB first
`include "tilt_fusion_balance_pd_top_defines.svh"
module tfb_smul (
  input  logic              clk,
  input  logic              rst,
  input  tfb_pkg::mul_req_t req,
  output tfb_pkg::mul_rsp_t rsp
);

  logic signed [tfb_pkg::W_MC-1:0]            mcand;
  logic [tfb_pkg::W_MP-1:0]                   mplier;
  logic [tfb_pkg::W_NDIG-1:0]                 cnt;
  logic                                       busy;
  logic                                       done;
  logic signed [tfb_pkg::W_PROD-1:0]          acc;
  logic signed [tfb_pkg::W_PROD-1:0]          acc_next;
  logic signed [tfb_pkg::W_MC+tfb_pkg::W_DIG:0] part;

  assign part = mcand * $signed({1'b0, mplier[tfb_pkg::W_MP-1 -: tfb_pkg::W_DIG]});
  assign acc_next = (acc <<< tfb_pkg::W_DIG) + tfb_pkg::W_PROD'(part);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.ndig;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == tfb_pkg::W_NDIG'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand  <= req.mcand;
      mplier <= req.mplier;
      acc    <= '0;
    end else if (busy) begin
      mplier <= mplier << tfb_pkg::W_DIG;
      acc    <= acc_next;
    end
  end

  assign rsp.busy    = busy;
  assign rsp.done    = done;
  assign rsp.product = acc;

  `TFB_ASSERT(a_start_idle, req.start |-> !busy && !done, "multiply started while busy")
  `TFB_ASSERT(a_busy_count, busy |-> cnt != '0, "busy with no digits left")
  `TFB_ASSERT_NEXT(a_done_pulse, done, !done && !busy, "done held past one cycle")

endmodule

### rtl/tilt_fusion_balance_pd_top.sv
`timescale 1ns / 1ps
// Tilt fusion and PD balance controller, top level
// One sensor tick in, one drive result out. The pitch rate, the second-order
// complementary filter and the PD law run as seven products on one shared
// multiplier that takes a 4-bit digit of its unsigned operand per cycle. An
// item steps through the products in turn and finishes once the result
// register is free; the result waits in its own register, so the next item
// is accepted while it is held.
`include "tilt_fusion_balance_pd_top_defines.svh"
module tilt_fusion_balance_pd_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [tfb_pkg::W_CFG_IDX-1:0]        cfg_index,
  input  logic [tfb_pkg::W_CFG_DATA-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [tfb_pkg::W_TILT-1:0]    tilt_measure,
  input  logic signed [tfb_pkg::W_GYRO-1:0]    gyro_pitch_raw,
  input  logic signed [tfb_pkg::W_GYRO-1:0]    gyro_yaw_raw,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tfb_pkg::W_DRIVE-1:0]   balance_drive,
  output logic                                 drive_clipped,
  output logic signed [tfb_pkg::W_ANGLE-1:0]   tilt_estimate,
  output logic signed [tfb_pkg::W_RATE-1:0]    pitch_rate
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RATE_A,
    S_RATE_B,
    S_INTEG,
    S_PROP,
    S_DT,
    S_PD_P,
    S_PD_D,
    S_FINISH
  } state_t;

  state_t            state;
  logic              issued;
  tfb_pkg::cfg_t     cfg;
  tfb_pkg::mul_req_t mreq;
  tfb_pkg::mul_rsp_t mrsp;

  logic signed [tfb_pkg::W_GYRO-1:0]  gp_r;
  logic signed [tfb_pkg::W_GYRO-1:0]  gy_r;
  logic signed [tfb_pkg::W_ERR-1:0]   err_r;
  logic signed [tfb_pkg::W_RA-1:0]    ra_r;
  logic signed [tfb_pkg::W_RATE-1:0]  rate_r;
  logic signed [tfb_pkg::W_ERR-1:0]   p_r;
  logic signed [tfb_pkg::W_SUM-1:0]   sp_r;
  logic signed [tfb_pkg::W_SUM-1:0]   s_r;
  logic signed [tfb_pkg::W_FI-1:0]    fi;
  logic signed [tfb_pkg::W_ANGLE-1:0] angle;

  logic signed [tfb_pkg::W_PDEV-1:0]  pitch_dev;
  logic signed [tfb_pkg::W_YMAG-1:0]  yaw_mag;
  logic signed [tfb_pkg::W_TDEV-1:0]  tilt_dev;
  logic signed [tfb_pkg::W_ERR-1:0]   err_in;
  logic signed [tfb_pkg::W_R24-1:0]   r24;
  logic signed [tfb_pkg::W_RFLR-1:0]  rate_flr;
  logic signed [tfb_pkg::W_RATE-1:0]  rate_next;
  logic signed [tfb_pkg::W_FSUM-1:0]  fi_sum;
  logic signed [tfb_pkg::W_FI-1:0]    fi_next;
  logic signed [tfb_pkg::W_X-1:0]     x_sum;
  logic signed [tfb_pkg::W_ASUM-1:0]  ang_sum;
  logic signed [tfb_pkg::W_ANGLE-1:0] angle_next;
  logic signed [tfb_pkg::W_PDERR-1:0] pd_err;
  logic signed [tfb_pkg::W_SUM-1:0]   prod_lo;
  logic signed [tfb_pkg::W_SUM-1:0]   s_up;
  logic signed [tfb_pkg::W_DRIVE-1:0] drive_trunc;
  logic                               clip_hi;
  logic                               clip_lo;
  logic                               in_xfer;
  logic                               out_free;

  tfb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tfb_smul u_smul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // operand and result arithmetic
  always_comb begin
    pitch_dev = tfb_pkg::W_PDEV'($signed({gp_r, 8'h00}))
              - tfb_pkg::W_PDEV'(cfg.gyro_pitch_offset);
    yaw_mag   = gy_r[tfb_pkg::W_GYRO-1] ? -tfb_pkg::W_YMAG'(gy_r) : tfb_pkg::W_YMAG'(gy_r);
    tilt_dev  = tfb_pkg::W_TDEV'(tilt_measure) - tfb_pkg::W_TDEV'(cfg.tilt_offset);
    err_in    = tfb_pkg::W_ERR'($signed({tilt_dev, 10'b0})) - tfb_pkg::W_ERR'(angle);

    r24 = tfb_pkg::W_R24'(ra_r) + $signed(mrsp.product[tfb_pkg::W_R24-1:0]);
    rate_flr = $signed(r24[tfb_pkg::W_R24-1:8]);
    if (rate_flr > tfb_pkg::W_RFLR'(tfb_pkg::RATE_MAX)) begin
      rate_next = tfb_pkg::RATE_MAX;
    end else if (rate_flr < tfb_pkg::W_RFLR'(tfb_pkg::RATE_MIN)) begin
      rate_next = tfb_pkg::RATE_MIN;
    end else begin
      rate_next = rate_flr[tfb_pkg::W_RATE-1:0];
    end

    fi_sum = tfb_pkg::W_FSUM'(fi)
           + tfb_pkg::W_FSUM'($signed(mrsp.product[tfb_pkg::W_PROD-1:32]));
    if (fi_sum > tfb_pkg::W_FSUM'(tfb_pkg::FI_MAX)) begin
      fi_next = tfb_pkg::FI_MAX;
    end else if (fi_sum < tfb_pkg::W_FSUM'(tfb_pkg::FI_MIN)) begin
      fi_next = tfb_pkg::FI_MIN;
    end else begin
      fi_next = fi_sum[tfb_pkg::W_FI-1:0];
    end

    x_sum = tfb_pkg::W_X'(fi) + tfb_pkg::W_X'(p_r) + tfb_pkg::W_X'($signed({rate_r, 4'b0}));

    ang_sum = tfb_pkg::W_ASUM'(angle)
            + tfb_pkg::W_ASUM'($signed(mrsp.product[tfb_pkg::W_PROD-1:32]));
    if (ang_sum > tfb_pkg::W_ASUM'(tfb_pkg::ANGLE_MAX)) begin
      angle_next = tfb_pkg::ANGLE_MAX;
    end else if (ang_sum < tfb_pkg::W_ASUM'(tfb_pkg::ANGLE_MIN)) begin
      angle_next = tfb_pkg::ANGLE_MIN;
    end else begin
      angle_next = ang_sum[tfb_pkg::W_ANGLE-1:0];
    end

    pd_err  = tfb_pkg::W_PDERR'(cfg.angle_setpoint) - tfb_pkg::W_PDERR'(angle);
    prod_lo = $signed(mrsp.product[tfb_pkg::W_SUM-1:0]);

    s_up        = s_r + tfb_pkg::DRIVE_ROUND;
    drive_trunc = s_r[tfb_pkg::W_SUM-1] ? $signed(s_up[40:24]) : $signed(s_r[40:24]);
    clip_hi     = s_r > tfb_pkg::DRIVE_LIM;
    clip_lo     = s_r < tfb_pkg::DRIVE_LIM_N;
  end

  // multiplier request per step
  always_comb begin
    mreq.start  = 1'b0;
    mreq.mcand  = '0;
    mreq.mplier = '0;
    mreq.ndig   = '0;
    unique case (state)
      S_RATE_A: begin
        mreq.start  = !issued;
        mreq.mcand  = tfb_pkg::W_MC'(pitch_dev);
        mreq.mplier = tfb_pkg::MPL_RATE;
        mreq.ndig   = tfb_pkg::NDIG_RATE;
      end
      S_RATE_B: begin
        mreq.start  = !issued;
        mreq.mcand  = tfb_pkg::W_MC'(yaw_mag);
        mreq.mplier = gy_r[tfb_pkg::W_GYRO-1] ? tfb_pkg::MPL_YAW_NEG : tfb_pkg::MPL_YAW_POS;
        mreq.ndig   = tfb_pkg::NDIG_YAW;
      end
      S_INTEG: begin
        mreq.start  = !issued;
        mreq.mcand  = tfb_pkg::W_MC'(err_r);
        mreq.mplier = tfb_pkg::MPL_INT;
        mreq.ndig   = tfb_pkg::NDIG_INT;
      end
      S_PROP: begin
        mreq.start  = !issued;
        mreq.mcand  = tfb_pkg::W_MC'(err_r);
        mreq.mplier = tfb_pkg::MPL_PROP;
        mreq.ndig   = tfb_pkg::NDIG_PROP;
      end
      S_DT: begin
        mreq.start  = !issued;
        mreq.mcand  = x_sum;
        mreq.mplier = tfb_pkg::MPL_DT;
        mreq.ndig   = tfb_pkg::NDIG_DT;
      end
      S_PD_P: begin
        mreq.start  = !issued;
        mreq.mcand  = tfb_pkg::W_MC'(pd_err);
        mreq.mplier = {cfg.angle_gain_p, 16'h0000};
        mreq.ndig   = tfb_pkg::NDIG_GAIN;
      end
      S_PD_D: begin
        mreq.start  = !issued;
        mreq.mcand  = tfb_pkg::W_MC'(rate_r);
        mreq.mplier = {cfg.angle_gain_d, 16'h0000};
        mreq.ndig   = tfb_pkg::NDIG_GAIN;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
      fi        <= '0;
      angle     <= '0;
    end else begin
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (mreq.start) begin
        issued <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            gp_r  <= gyro_pitch_raw;
            gy_r  <= gyro_yaw_raw;
            err_r <= err_in;
            state <= S_RATE_A;
          end
        end
        S_RATE_A: begin
          if (mrsp.done) begin
            ra_r   <= mrsp.product[tfb_pkg::W_RA-1:0];
            issued <= 1'b0;
            state  <= S_RATE_B;
          end
        end
        S_RATE_B: begin
          if (mrsp.done) begin
            rate_r <= rate_next;
            issued <= 1'b0;
            state  <= S_INTEG;
          end
        end
        S_INTEG: begin
          if (mrsp.done) begin
            fi     <= fi_next;
            issued <= 1'b0;
            state  <= S_PROP;
          end
        end
        S_PROP: begin
          if (mrsp.done) begin
            p_r    <= tfb_pkg::W_ERR'($signed(mrsp.product[tfb_pkg::W_PROD-1:32]));
            issued <= 1'b0;
            state  <= S_DT;
          end
        end
        S_DT: begin
          if (mrsp.done) begin
            angle  <= angle_next;
            issued <= 1'b0;
            state  <= S_PD_P;
          end
        end
        S_PD_P: begin
          if (mrsp.done) begin
            sp_r   <= prod_lo;
            issued <= 1'b0;
            state  <= S_PD_D;
          end
        end
        S_PD_D: begin
          if (mrsp.done) begin
            s_r    <= sp_r - prod_lo;
            issued <= 1'b0;
            state  <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            drive_clipped <= clip_hi || clip_lo;
            tilt_estimate <= angle;
            pitch_rate    <= rate_r;
            if (clip_hi) begin
              balance_drive <= tfb_pkg::DRIVE_MAX;
            end else if (clip_lo) begin
              balance_drive <= tfb_pkg::DRIVE_MIN;
            end else begin
              balance_drive <= drive_trunc;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TFB_ASSERT(a_clip_at_limit, out_valid && drive_clipped |-> balance_drive == tfb_pkg::DRIVE_MAX || balance_drive == tfb_pkg::DRIVE_MIN, "clipped drive not at a limit")
  `TFB_ASSERT(a_angle_bound, angle <= tfb_pkg::ANGLE_MAX && angle >= tfb_pkg::ANGLE_MIN, "angle estimate out of range")
  `TFB_ASSERT(a_done_in_step, mrsp.done |-> issued && state != S_IDLE && state != S_FINISH, "product done outside a multiply step")

endmodule
